/* sv/zlep_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the zero-length-encoded event word parser.
// No dependencies; imported by zlep_framer and zle_event_word_parser.
package zlep_pkg;

  localparam int WordW       = 32;
  localparam int SizeW       = 28;
  localparam int SampleW     = 16;
  localparam int CountW      = 20;
  localparam int HeaderWords = 4;

  // Control codes in bits 31..30 of a payload word
  localparam logic [1:0] CtrlGood = 2'b11;
  localparam logic [1:0] CtrlSkip = 2'b01;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_SKIP = 2'd2,
    KIND_BAD  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                word_kind;
    logic [SampleW-1:0]   sample_first;
    logic [SampleW-1:0]   sample_second;
    logic [CountW-1:0]    word_count;
    logic [CountW-1:0]    pair_index;
    logic                 event_end;
  } result_t;

endpackage

/* sv/zle_event_word_parser.sv */
`timescale 1ns / 1ps
// Top level of the zero-length-encoded event word parser.
// Depends on zlep_pkg and zlep_framer.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid_i/in_ready_o| buffer_word_i, buffer_start_i
//  output  | out_valid_o/out_ready_i | word_kind_o, sample_first_o,
//          |                      | sample_second_o, word_count_o,
//          |                      | pair_index_o, event_end_o
//
// One word per clock sustained while the output register keeps being taken. A word
// is held in the input register, is classified there against the framing state, and
// its result (if any) is loaded into the output register once that register is free.
// Reset clears both valid flags and the framing state (header expected).
// Stalls: the input register moves on whenever the output register is empty or
// being taken; a word that yields no result still uses that slot.
module zle_event_word_parser import zlep_pkg::*; #(
  parameter int HEADER_WORDS = HeaderWords
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [WordW-1:0]   buffer_word_i,
  input  logic               buffer_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         word_kind_o,
  output logic [SampleW-1:0] sample_first_o,
  output logic [SampleW-1:0] sample_second_o,
  output logic [CountW-1:0]  word_count_o,
  output logic [CountW-1:0]  pair_index_o,
  output logic               event_end_o
);

  // Input register
  logic             s1_valid_q;
  logic [WordW-1:0] s1_word_q;
  logic             s1_start_q;

  // Output register
  logic    out_valid_q;
  result_t out_q;

  logic    out_free;
  logic    s1_adv;
  logic    has_res;
  result_t res;

  // Output slot can take a new result when empty or being drained this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Capture the word on accept; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_word_q  <= buffer_word_i;
      s1_start_q <= buffer_start_i;
    end
  end

  zlep_framer #(
    .HEADER_WORDS(HEADER_WORDS)
  ) u_framer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (s1_adv),
    .word_i   (s1_word_q),
    .start_i  (s1_start_q),
    .has_res_o(has_res),
    .res_o    (res)
  );

  // Load a result when the slot is free; drop the word if it yields nothing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q && has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && has_res) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign word_kind_o     = out_q.word_kind;
  assign sample_first_o  = out_q.sample_first;
  assign sample_second_o = out_q.sample_second;
  assign word_count_o    = out_q.word_count;
  assign pair_index_o    = out_q.pair_index;
  assign event_end_o     = out_q.event_end;

endmodule

/* sv/zlep_framer.sv */
`timescale 1ns / 1ps
// Event framing state and word classification for one buffered word.
// Depends on zlep_pkg for the result struct and code constants.
module zlep_framer import zlep_pkg::*; #(
  parameter int HEADER_WORDS = HeaderWords
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [WordW-1:0] word_i,
  input  logic             start_i,
  output logic             has_res_o,
  output result_t          res_o
);

  localparam logic [SizeW-1:0] MinSize  = SizeW'(HEADER_WORDS + 1);
  localparam logic [SizeW-1:0] LastHead = SizeW'(HEADER_WORDS);

  logic [SizeW-1:0]  pos_q, pos_d, pos_cur, size;
  logic [SizeW-1:0]  len_q, len_d;
  logic [CountW-1:0] pair_q, pair_d;
  logic [SizeW:0]    pos_inc;
  logic [1:0]        ctrl;

  assign pos_cur = start_i ? '0 : pos_q;
  assign size    = word_i[SizeW-1:0];
  assign pos_inc = {1'b0, pos_cur} + {{SizeW{1'b0}}, 1'b1};
  assign ctrl    = word_i[WordW-1 -: 2];

  always_comb begin
    pos_d     = pos_q;
    len_d     = len_q;
    pair_d    = pair_q;
    has_res_o = 1'b0;
    res_o     = '0;
    if (pos_cur == '0) begin
      pair_d = '0;
      if (size < MinSize) begin
        len_d           = '0;
        pos_d           = '0;
        has_res_o       = 1'b1;
        res_o.word_kind = KIND_BAD;
        res_o.event_end = 1'b1;
      end else begin
        len_d = size;
        pos_d = SizeW'(1);
      end
    end else begin
      if (pos_inc >= {1'b0, len_q}) pos_d = '0;
      else                          pos_d = pos_inc[SizeW-1:0];
      if (pos_cur > LastHead) begin
        has_res_o       = 1'b1;
        res_o.event_end = (pos_d == '0);
        if (ctrl == CtrlGood) begin
          res_o.word_kind  = KIND_GOOD;
          res_o.word_count = word_i[CountW-1:0];
          pair_d           = CountW'(1);
        end else if (ctrl == CtrlSkip) begin
          res_o.word_kind  = KIND_SKIP;
          res_o.word_count = word_i[CountW-1:0];
        end else begin
          res_o.word_kind     = KIND_DATA;
          res_o.sample_first  = word_i[SampleW-1:0];
          res_o.sample_second = word_i[WordW-1 -: SampleW];
          res_o.pair_index    = pair_q;
          pair_d              = pair_q + CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= '0;
      pair_q <= '0;
    end else if (adv_i) begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      pair_q <= pair_d;
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for zle_event_word_parser: drives readout words with random
// gaps and output stalls, predicts every result and compares it field by field.
// Depends on zlep_pkg and the parser RTL only.
module testbench;
  import zlep_pkg::*;

  localparam int RandomWords = 1000;
  localparam int StallLimit  = 500;   // cycles with no handshake on either side
  localparam int TailCycles  = 10;    // extra cycles waited after the owed results have drained
  localparam int PrintLimit  = 40;

  logic              clk_i;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_ready_o;
  logic [WordW-1:0]  buffer_word_i   = '0;
  logic              buffer_start_i  = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i     = 1'b0;
  logic [1:0]        word_kind_o;
  logic [SampleW-1:0] sample_first_o;
  logic [SampleW-1:0] sample_second_o;
  logic [CountW-1:0] word_count_o;
  logic [CountW-1:0] pair_index_o;
  logic              event_end_o;

  // While calm is set neither side idles.
  bit calm = 1'b0;
  int words_sent = 0;
  int restarts = 0;

  zle_event_word_parser u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .buffer_word_i   (buffer_word_i),
    .buffer_start_i  (buffer_start_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .word_kind_o     (word_kind_o),
    .sample_first_o  (sample_first_o),
    .sample_second_o (sample_second_o),
    .word_count_o    (word_count_o),
    .pair_index_o    (pair_index_o),
    .event_end_o     (event_end_o)
  );

  // Framing predictor plus the queue of results still owed by the parser.
  class parse_scoreboard;
    logic [SizeW-1:0]  word_pos;
    logic [SizeW-1:0]  event_len;
    logic [CountW-1:0] pair_cnt;
    result_t           expected_results[$];
    int                errors;
    int                checked;
    int                malformed;

    function new();
      word_pos  = '0;
      event_len = '0;
      pair_cnt  = '0;
      errors    = 0;
      checked   = 0;
      malformed = 0;
    endfunction

    function void report(string what);
      if (errors < PrintLimit) begin
        $display("ERROR @%0t: %s", $realtime, what);
      end
      errors++;
    endfunction

    // Append one owed result at the tail of the queue.
    function void owe_result(result_t r);
      expected_results = {expected_results, r};
    endfunction

    // Advance the framing state by one accepted word and queue its result, if any.
    function void frame_word(logic [WordW-1:0] w, logic start);
      result_t          r;
      logic [SizeW-1:0] size;
      logic [SizeW:0]   next_pos;
      logic [1:0]       ctrl;
      r = '0;
      if (start) begin
        word_pos = '0;
      end
      if (word_pos == '0) begin
        // header word: latch the size, clear the pair counter
        size     = w[SizeW-1:0];
        pair_cnt = '0;
        if (size < SizeW'(HeaderWords + 1)) begin
          event_len   = '0;
          r.word_kind = KIND_BAD;
          r.event_end = 1'b1;
          owe_result(r);
          malformed++;
        end else begin
          event_len = size;
          word_pos  = SizeW'(1);
        end
        return;
      end
      next_pos = {1'b0, word_pos} + (SizeW + 1)'(1);
      if (next_pos >= {1'b0, event_len}) begin
        word_pos = '0;
      end else begin
        word_pos = next_pos[SizeW-1:0];
      end
      // remaining header words and the waveform size word say nothing
      if ((next_pos - (SizeW + 1)'(1)) <= (SizeW + 1)'(HeaderWords)) begin
        return;
      end
      ctrl = w[31:30];
      if (ctrl == CtrlGood) begin
        r.word_kind  = KIND_GOOD;
        r.word_count = w[CountW-1:0];
        pair_cnt     = CountW'(1);
      end else if (ctrl == CtrlSkip) begin
        r.word_kind  = KIND_SKIP;
        r.word_count = w[CountW-1:0];
      end else begin
        r.word_kind     = KIND_DATA;
        r.sample_first  = w[15:0];
        r.sample_second = w[31:16];
        r.pair_index    = pair_cnt;
        pair_cnt        = pair_cnt + CountW'(1);
      end
      r.event_end = (word_pos == '0);
      owe_result(r);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result kind=%0d", got.word_kind));
        return;
      end
      exp_r = expected_results.pop_front();
      checked++;
      if (got.word_kind !== exp_r.word_kind)
        report($sformatf("word_kind got %0d want %0d", got.word_kind, exp_r.word_kind));
      if (got.sample_first !== exp_r.sample_first)
        report($sformatf("sample_first got %h want %h", got.sample_first,
                         exp_r.sample_first));
      if (got.sample_second !== exp_r.sample_second)
        report($sformatf("sample_second got %h want %h", got.sample_second,
                         exp_r.sample_second));
      if (got.word_count !== exp_r.word_count)
        report($sformatf("word_count got %h want %h", got.word_count, exp_r.word_count));
      if (got.pair_index !== exp_r.pair_index)
        report($sformatf("pair_index got %h want %h", got.pair_index, exp_r.pair_index));
      if (got.event_end !== exp_r.event_end)
        report($sformatf("event_end got %b want %b", got.event_end, exp_r.event_end));
    endfunction
  endclass

  parse_scoreboard sb = new();

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one; none at all while calm.
  function automatic int idle_len();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Offer one word, hold it until taken, then note it for prediction.
  task automatic send_word(input logic [WordW-1:0] w, input logic start);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    buffer_word_i  <= w;
    buffer_start_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    sb.frame_word(w, start);
    words_sent++;
    if (start) restarts++;
  endtask

  // Header with random top nibble, then count-1 random words.
  task automatic send_event(input int unsigned size, input int unsigned count,
                            input logic start);
    logic [WordW-1:0] hdr;
    hdr = $urandom;
    hdr[SizeW-1:0] = size[SizeW-1:0];
    send_word(hdr, start);
    for (int unsigned i = 1; i < count; i++) begin
      send_word($urandom, 1'b0);
    end
  endtask

  // Hold the input off until the parser has delivered everything owed.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_results.size() != 0);
  endtask

  // Receiver: check on each output handshake, stall at random.
  initial begin : receiver
    int hold;
    result_t got;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.word_kind     = kind_e'(word_kind_o);
        got.sample_first  = sample_first_o;
        got.sample_second = sample_second_o;
        got.word_count    = word_count_o;
        got.pair_index    = pair_index_o;
        got.event_end     = event_end_o;
        sb.check_result(got);
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 99) < 25) hold = idle_len();
      end
    end
  end

  // Watchdog: give up when neither channel moves for too long.
  initial begin : watchdog
    int stale;
    stale = 0;
    while (stale < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stale = 0;
      else stale++;
    end
    $display("ERROR: no handshake for %0d cycles", StallLimit);
    $display("zle_event_word_parser: mismatch");
    $finish;
  end

  initial begin : stimulus
    int unsigned size;
    int pick;
    bit restart;
    bit mid_drain;
    restart   = 1'b0;
    mid_drain = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Event of exactly header plus waveform size: no result, end not reported.
    send_word(32'hF000_0005, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hC000_0000, 1'b0);
    send_word(32'h4000_0000, 1'b0);
    // Malformed sizes: zero, and one short of the minimum with top bits set.
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hF000_0004, 1'b0);
    // Nine-word event: data, good control at max count, data with binary 10,
    // skip control closing the event.
    send_word(32'h0000_0009, 1'b0);
    send_word(32'h1234_5678, 1'b0);
    send_word(32'h8765_4321, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0FFF_FFFF, 1'b0);
    send_word(32'h0000_FFFF, 1'b0);
    send_word(32'hC00F_FFFF, 1'b0);
    send_word(32'hBFFF_FFFF, 1'b0);
    send_word(32'h4000_0000, 1'b0);
    // Open event cut short by a buffer start.
    send_word(32'h0000_0014, 1'b0);
    send_word(32'h5555_5555, 1'b0);
    send_word(32'hAAAA_AAAA, 1'b0);
    send_word(32'h0000_0006, 1'b1);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h3FFF_FFFF, 1'b0);
    drain_results();

    // Random part: mostly well-formed events, plus malformed sizes, cut-off
    // events and absurd sizes that only a buffer start can end.
    while (words_sent < RandomWords) begin
      if ($urandom_range(0, 9) == 0) calm = ~calm;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        size = HeaderWords + 1 + $urandom_range(0, 12);
        if (pick < 4) size += $urandom_range(0, 200);
        send_event(size, size, restart || ($urandom_range(0, 9) == 0));
        restart = 1'b0;
      end else if (pick < 82) begin
        size = $urandom_range(0, HeaderWords);
        send_event(size, 1, restart || ($urandom_range(0, 9) == 0));
        restart = 1'b0;
      end else if (pick < 94) begin
        size = HeaderWords + 2 + $urandom_range(0, 12);
        send_event(size, $urandom_range(1, size - 1), restart || ($urandom_range(0, 9) == 0));
        restart = 1'b1;
      end else begin
        size = $urandom_range(64, 32'h0FFF_FFFF);
        send_event(size, $urandom_range(1, 30), restart || ($urandom_range(0, 9) == 0));
        restart = 1'b1;
      end
      if (!mid_drain && words_sent >= RandomWords / 2) begin
        drain_results();
        mid_drain = 1'b1;
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_results.size() != 0);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.expected_results.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.expected_results.size()));
    end

    $display("Run: %0d words sent, %0d buffer starts, %0d malformed headers.",
             words_sent, restarts, sb.malformed);
    $display("Run: %0d results compared, %0d field errors.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("zle_event_word_parser: match");
    end else begin
      $display("zle_event_word_parser: mismatch");
    end
    $finish;
  end

endmodule
